### hdl/sha256_message_hasher_top_macros.svh
// Assertion macros for the SHA-256 hasher.
`ifndef SHA256_MESSAGE_HASHER_TOP_MACROS_SVH
`define SHA256_MESSAGE_HASHER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst, a, c)
`define SHA_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

### hdl/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;
   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
   } state_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [7:0] PAD_BYTE = 8'h80;
endpackage
`default_nettype wire

### hdl/sha_round.sv
`timescale 1ns / 1ps
`default_nettype none
// One SHA-256 round plus one schedule step; shared by all 64 rounds.
module sha_round (
   input  wire logic [31:0] v_a, v_b, v_c, v_d, v_e, v_f, v_g, v_h,
   input  wire logic [31:0] w_t,
   input  wire logic [31:0] k_t,
   input  wire logic [31:0] w_m16, w_m15, w_m7, w_m2,
   output logic [31:0] new_a,
   output logic [31:0] new_e,
   output logic [31:0] w_next
);
   logic [31:0] s0, s1, ch, maj, t1, t2, ls0, ls1;
   always_comb begin
      s1  = {v_e[5:0], v_e[31:6]} ^ {v_e[10:0], v_e[31:11]} ^ {v_e[24:0], v_e[31:25]};
      ch  = (v_e & v_f) ^ (~v_e & v_g);
      t1  = v_h + s1 + ch + k_t + w_t;
      s0  = {v_a[1:0], v_a[31:2]} ^ {v_a[12:0], v_a[31:13]} ^ {v_a[21:0], v_a[31:22]};
      maj = (v_a & v_b) ^ (v_a & v_c) ^ (v_b & v_c);
      t2  = s0 + maj;
      new_a = t1 + t2;
      new_e = v_d + t1;
      ls0 = {w_m15[6:0], w_m15[31:7]} ^ {w_m15[17:0], w_m15[31:18]} ^ (w_m15 >> 3);
      ls1 = {w_m2[16:0], w_m2[31:17]} ^ {w_m2[18:0], w_m2[31:19]} ^ (w_m2 >> 10);
      w_next = w_m16 + ls0 + w_m7 + ls1;
   end
endmodule
`default_nettype wire

### hdl/sha256_message_hasher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Plain byte (no block completion): ready again in the next cycle.
// Byte completing a block: busy through 16 word loads, 64 rounds and the fold.
// End of message: a pad step, then load, rounds and fold per padded block (one or two;
//   an end on a block-completing byte first compresses that block), then 8 digest words,
//   1/cycle while rsp_ready is high. The single shared round unit does 1 round/cycle.
// Synchronous active-high reset clears control, counters, and hash state to the IV.
module sha256_message_hasher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_final_word
);
   import sha_pkg::*;
`include "sha256_message_hasher_top_macros.svh"

   state_type state_ff, state_in;
   logic [31:0] blk_ff [16];            // block buffer incl. padding, first byte in bits 31..24
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] hash_ff [8];
   logic [31:0] wv_ff [8];
   logic [31:0] win_ff [16];            // schedule shift window, win_ff[15] newest
   logic [6:0]  rnd_ff, rnd_in;         // load/round counter
   logic        ending_ff, ending_in;   // padding in progress
   logic        second_ff, second_in;   // padding needs a length-only block
   logic        pad_ff, pad_in;         // end came with a block-completing byte
   logic [2:0]  oidx_ff, oidx_in;

   logic take;
   logic [31:0] new_a, new_e, w_next, w_t;
   logic [31:0] pad_blk [16];           // block with padding and length applied

   assign take = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_digest_word = hash_ff[oidx_ff];
   assign rsp_word_index = oidx_ff;
   assign rsp_final_word = (oidx_ff == 3'd7);

   // rounds 0..15 take the loaded word, later ones the fresh schedule word
   assign w_t = (rnd_ff < 7'd16) ? win_ff[rnd_ff[3:0]] : w_next;

   sha_round u_round (
      .v_a(wv_ff[0]), .v_b(wv_ff[1]), .v_c(wv_ff[2]), .v_d(wv_ff[3]),
      .v_e(wv_ff[4]), .v_f(wv_ff[5]), .v_g(wv_ff[6]), .v_h(wv_ff[7]),
      .w_t(w_t), .k_t(ROUND_CONST[rnd_ff[5:0]]),
      .w_m16(win_ff[0]), .w_m15(win_ff[1]), .w_m7(win_ff[9]), .w_m2(win_ff[14]),
      .new_a(new_a), .new_e(new_e), .w_next(w_next));

   // 0x80 at the fill point, zeros above, length in the last 8 bytes when it fits
   always_comb begin
      logic [31:0] len_word;
      for (int j = 0; j < 16; j++) begin
         len_word = (j == 14) ? len_ff[63:32] : len_ff[31:0];
         for (int l = 0; l < 4; l++) begin
            if (6'(4*j + l) == fill_ff) pad_blk[j][31 - 8*l -: 8] = PAD_BYTE;
            else if (6'(4*j + l) > fill_ff) begin
               if (j >= 14 && fill_ff < 6'd56)
                  pad_blk[j][31 - 8*l -: 8] = len_word[31 - 8*l -: 8];
               else
                  pad_blk[j][31 - 8*l -: 8] = 8'h00;
            end else pad_blk[j][31 - 8*l -: 8] = blk_ff[j][31 - 8*l -: 8];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      rnd_in    = rnd_ff;
      ending_in = ending_ff;
      second_in = second_ff;
      pad_in    = pad_ff;
      oidx_in   = oidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_has_byte) begin
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + 64'd8;
               end
               if (req_has_byte && fill_ff == 6'd63) begin
                  state_in = ST_LOAD;
                  rnd_in   = '0;
                  pad_in   = req_end_of_message;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // padding bytes written this cycle; block then compressed
            ending_in = 1'b1;
            second_in = (fill_ff >= 6'd56);
            state_in  = ST_LOAD;
            rnd_in    = '0;
         end
         ST_LOAD: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd15) begin
               state_in = ST_ROUND;
               rnd_in   = '0;
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            rnd_in = '0;
            fill_in = '0;
            if (!ending_ff) begin
               // full block done; an end seen with its last byte pads a fresh block
               state_in = pad_ff ? ST_PAD : ST_IDLE;
               pad_in   = 1'b0;
            end else if (second_ff) begin
               second_in = 1'b0;
               state_in  = ST_LOAD;       // length-only block, prepared in fold
            end else begin
               state_in = ST_OUT;
               oidx_in  = '0;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_in  = ST_IDLE;
                  ending_in = 1'b0;
                  fill_in   = '0;
                  len_in    = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         len_ff    <= '0;
         rnd_ff    <= '0;
         ending_ff <= 1'b0;
         second_ff <= 1'b0;
         pad_ff    <= 1'b0;
         oidx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         len_ff    <= len_in;
         rnd_ff    <= rnd_in;
         ending_ff <= ending_in;
         second_ff <= second_in;
         pad_ff    <= pad_in;
         oidx_ff   <= oidx_in;
      end
   end

   // hash state: IV after reset and after the last digest word
   always_ff @(posedge clock) begin
      if (reset || (state_ff == ST_OUT && rsp_ready && oidx_ff == 3'd7)) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
      end else if (state_ff == ST_FOLD) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + wv_ff[i];
      end
   end

   // block buffer, window and working variables (payload)
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_has_byte)
               blk_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'd0} +: 8] <= req_data_byte;
         end
         ST_PAD: begin
            for (int j = 0; j < 16; j++) blk_ff[j] <= pad_blk[j];
         end
         ST_LOAD: begin
            // one word a cycle into the window; a..h take the hash at the start
            for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
            win_ff[15] <= blk_ff[rnd_ff[3:0]];
            for (int i = 0; i < 8; i++) wv_ff[i] <= hash_ff[i];
         end
         ST_ROUND: begin
            wv_ff[0] <= new_a;
            wv_ff[1] <= wv_ff[0];
            wv_ff[2] <= wv_ff[1];
            wv_ff[3] <= wv_ff[2];
            wv_ff[4] <= new_e;
            wv_ff[5] <= wv_ff[4];
            wv_ff[6] <= wv_ff[5];
            wv_ff[7] <= wv_ff[6];
            if (rnd_ff >= 7'd16) begin
               // window slides once per schedule word from round 16 on
               for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
               win_ff[15] <= w_next;
            end
         end
         ST_FOLD: begin
            if (second_ff) begin
               for (int j = 0; j < 14; j++) blk_ff[j] <= 32'h0;
               blk_ff[14] <= len_ff[63:32];
               blk_ff[15] <= len_ff[31:0];
            end
         end
         default: ;
      endcase
   end

   `SHA_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `SHA_ASSERT_IMP(a_final_idx, clock, reset, rsp_valid && rsp_final_word, rsp_word_index == 3'd7)
   `SHA_ASSERT_NXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(oidx_ff))
   `SHA_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
endmodule
`default_nettype wire
